// ===== sv/mpmh_pkg.sv =====
// ----------------------------------------------------------------------------
// mpmh_pkg: shared types and constants
// Command, drive and status codes, beat payloads and the configuration
// register set of the move-and-hold position controller.
// ----------------------------------------------------------------------------
package mpmh_pkg;

    localparam int PosW   = 24;
    localparam int TolW   = 16;
    localparam int SpeedW = 8;
    localparam int MsW    = 16;
    localparam int LevelW = 4;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    typedef enum logic [1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_MOVE    = 2'd1,
        CMD_RELEASE = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        DRV_NONE  = 3'd0,
        DRV_COAST = 3'd1,
        DRV_BRAKE = 3'd2,
        DRV_INC   = 3'd3,
        DRV_DEC   = 3'd4
    } drive_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_MOVING  = 3'd1,
        ST_REACHED = 3'd2,
        ST_NEAR    = 3'd3,
        ST_TIMEOUT = 3'd4,
        ST_STUCK   = 3'd5,
        ST_HOLDING = 3'd6,
        ST_INVALID = 3'd7
    } status_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_POS_TOL     = 3'd0,
        CFG_HOLD_TOL    = 3'd1,
        CFG_SLOW_BAND   = 3'd2,
        CFG_NORMAL_SPD  = 3'd3,
        CFG_SLOW_SPD    = 3'd4,
        CFG_HOLD_SPD    = 3'd5,
        CFG_TIMEOUT_MS  = 3'd6,
        CFG_STUCK_MS    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic signed [PosW-1:0]  position;
        logic                    ms_elapsed;
        logic [LevelW-1:0]       level;
        logic signed [PosW-1:0]  target_position;
    } item_t;

    typedef struct packed {
        drive_t              drive;
        logic [SpeedW-1:0]   speed;
        status_t             status;
        logic                hold_active;
    } result_t;

    typedef struct packed {
        logic [TolW-1:0]    position_tolerance;
        logic [TolW-1:0]    hold_tolerance;
        logic [TolW-1:0]    slow_band;
        logic [SpeedW-1:0]  far_duty;
        logic [SpeedW-1:0]  near_duty;
        logic [SpeedW-1:0]  hold_speed;
        logic [MsW-1:0]     timeout_limit;
        logic [MsW-1:0]     stuck_time_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        position_tolerance: 16'd5,
        hold_tolerance:     16'd5,
        slow_band:          16'd50,
        far_duty:           8'd200,
        near_duty:          8'd100,
        hold_speed:         8'd80,
        timeout_limit:      16'd5000,
        stuck_time_ms:      16'd500
    };

endpackage

// ===== sv/mpmh_stream_if.sv =====
// ----------------------------------------------------------------------------
// mpmh_stream_if: valid/ready channel
// One beat moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface mpmh_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/mpmh_cfg.sv =====
// ----------------------------------------------------------------------------
// mpmh_cfg: configuration register file
// Eight write-only registers, loaded through a plain indexed write port.
// ----------------------------------------------------------------------------
module mpmh_cfg
    import mpmh_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata,
    output cfg_t                cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_POS_TOL:    cfg_next.position_tolerance = cfg_wdata;
                CFG_HOLD_TOL:   cfg_next.hold_tolerance     = cfg_wdata;
                CFG_SLOW_BAND:  cfg_next.slow_band          = cfg_wdata;
                CFG_NORMAL_SPD: cfg_next.far_duty           = cfg_wdata[SpeedW-1:0];
                CFG_SLOW_SPD:   cfg_next.near_duty          = cfg_wdata[SpeedW-1:0];
                CFG_HOLD_SPD:   cfg_next.hold_speed         = cfg_wdata[SpeedW-1:0];
                CFG_TIMEOUT_MS: cfg_next.timeout_limit      = cfg_wdata;
                CFG_STUCK_MS:   cfg_next.stuck_time_ms      = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/mpmh_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpmh_ctrl: move/hold decision logic and controller state
// Evaluate one beat against the current state and update the state when
// the beat advances to the result register.
// ----------------------------------------------------------------------------
module mpmh_ctrl
    import mpmh_pkg::*;
#(
    parameter int MAX_LEVEL_VALUE = 10
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    fire,
    input  item_t   item,
    output result_t res
);

    localparam logic [MsW-1:0] MsMax = {MsW{1'b1}};

    logic                   moving_reg, moving_next;
    logic                   hold_on_reg, hold_on_next;
    logic                   release_reg, release_next;
    logic signed [PosW-1:0] hold_target_reg, hold_target_next;
    logic signed [PosW-1:0] last_pos_reg, last_pos_next;
    logic [MsW-1:0]         elapsed_reg, elapsed_next;
    logic [MsW-1:0]         since_reg, since_next;

    logic                   restart;
    logic signed [PosW-1:0] ref_pos;
    logic signed [PosW:0]   err;
    logic signed [PosW:0]   err_neg;
    logic [PosW-1:0]        err_mag;
    logic                   in_pos_tol;
    logic                   in_hold_tol;
    logic [SpeedW-1:0]      move_speed;
    drive_t                 toward;
    drive_t                 end_drive;
    logic [MsW-1:0]         elapsed_tick;
    logic [MsW-1:0]         since_tick;

    always_comb
    begin
        restart = (item.cmd == CMD_MOVE) &&
                  (item.level <= LevelW'(MAX_LEVEL_VALUE));
        // one subtractor serves both the move target and the hold target
        ref_pos = (item.cmd == CMD_MOVE) ? item.target_position : hold_target_reg;
        err     = {ref_pos[PosW-1], ref_pos} - {item.position[PosW-1], item.position};
        err_neg = -err;
        err_mag = err[PosW] ? err_neg[PosW-1:0] : err[PosW-1:0];

        in_pos_tol  = err_mag <= PosW'(cfg.position_tolerance);
        in_hold_tol = err_mag <= PosW'(cfg.hold_tolerance);
        move_speed  = (err_mag <= PosW'(cfg.slow_band)) ? cfg.near_duty : cfg.far_duty;
        toward      = err[PosW] ? DRV_DEC : DRV_INC;
        end_drive   = release_reg ? DRV_COAST : DRV_BRAKE;

        elapsed_tick = elapsed_reg;
        since_tick   = since_reg;
        if (moving_reg && item.ms_elapsed && !restart)
        begin
            elapsed_tick = (elapsed_reg != MsMax) ? elapsed_reg + 1'b1 : elapsed_reg;
            since_tick   = (since_reg != MsMax) ? since_reg + 1'b1 : since_reg;
        end

        moving_next      = moving_reg;
        hold_on_next     = hold_on_reg;
        release_next     = release_reg;
        hold_target_next = hold_target_reg;
        last_pos_next    = last_pos_reg;
        elapsed_next     = elapsed_tick;
        since_next       = since_tick;

        res.drive  = DRV_NONE;
        res.speed  = '0;
        res.status = ST_IDLE;

        case (item.cmd)
            CMD_MOVE:
            begin
                if (!restart)
                begin
                    res.status = ST_INVALID;
                end
                else
                begin
                    hold_target_next = item.target_position;
                    if (in_pos_tol)
                    begin
                        moving_next  = 1'b0;
                        res.status   = ST_NEAR;
                        hold_on_next = (item.level != '0);
                        if (item.level == '0)
                        begin
                            res.drive = DRV_COAST;
                        end
                    end
                    else
                    begin
                        moving_next   = 1'b1;
                        release_next  = (item.level == '0);
                        elapsed_next  = '0;
                        since_next    = '0;
                        last_pos_next = item.position;
                        res.status    = ST_MOVING;
                        res.drive     = toward;
                        res.speed     = move_speed;
                    end
                end
            end
            CMD_RELEASE:
            begin
                hold_on_next = 1'b0;
                res.status   = moving_reg ? ST_MOVING : ST_IDLE;
            end
            CMD_SAMPLE:
            begin
                if (moving_reg)
                begin
                    if (in_pos_tol || (elapsed_tick > cfg.timeout_limit))
                    begin
                        moving_next  = 1'b0;
                        hold_on_next = !release_reg;
                        res.drive    = end_drive;
                        res.status   = in_pos_tol ? ST_REACHED : ST_TIMEOUT;
                    end
                    else
                    begin
                        if (item.position != last_pos_reg)
                        begin
                            last_pos_next = item.position;
                            since_next    = '0;
                        end
                        if (since_next > cfg.stuck_time_ms)
                        begin
                            moving_next  = 1'b0;
                            hold_on_next = !release_reg;
                            res.drive    = end_drive;
                            res.status   = ST_STUCK;
                        end
                        else
                        begin
                            res.status = ST_MOVING;
                            res.drive  = toward;
                            res.speed  = move_speed;
                        end
                    end
                end
                else if (hold_on_reg)
                begin
                    res.status = ST_HOLDING;
                    if (in_hold_tol)
                    begin
                        res.drive = DRV_BRAKE;
                    end
                    else
                    begin
                        res.drive = toward;
                        res.speed = cfg.hold_speed;
                    end
                end
            end
            default:
            begin
                // unused command: report only
                res.status = moving_reg ? ST_MOVING : (hold_on_reg ? ST_HOLDING : ST_IDLE);
            end
        endcase

        res.hold_active = hold_on_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            moving_reg      <= 1'b0;
            hold_on_reg     <= 1'b0;
            release_reg     <= 1'b0;
            hold_target_reg <= '0;
            last_pos_reg    <= '0;
            elapsed_reg     <= '0;
            since_reg       <= '0;
        end
        else if (fire)
        begin
            moving_reg      <= moving_next;
            hold_on_reg     <= hold_on_next;
            release_reg     <= release_next;
            hold_target_reg <= hold_target_next;
            last_pos_reg    <= last_pos_next;
            elapsed_reg     <= elapsed_next;
            since_reg       <= since_next;
        end
    end

endmodule

// ===== sv/motor_position_move_and_hold.sv =====
// ----------------------------------------------------------------------------
// motor_position_move_and_hold: bang-bang move-and-hold position controller
// Input register, combinational decision logic, result register.
// ----------------------------------------------------------------------------
// Takes one beat per clock unless the result side stalls, and returns
// exactly one result beat per input beat, in order. A beat is captured into
// the input register, evaluated by the decision logic in the next cycle and
// written to the result register once that register is free. Throughput is
// one beat per cycle while result.ready is high; it is set by the result
// register alone, which frees up in the same cycle its current beat is taken
// downstream. The controller state (move flag, hold flag, targets, ms
// counters) updates exactly when a beat advances into the result register,
// so back-to-back beats see the state left by their predecessor. cmd 1
// starts a move at the given level, or reports already-near when the target
// is within position_tolerance; levels above MAX_LEVEL_VALUE give status
// invalid and change only the ms counters of a running move. cmd 0 is an
// encoder sample: during a move it checks reached, then timeout, then stuck,
// and otherwise drives toward the target (slow duty inside slow_band); with
// hold enabled it brakes inside hold_tolerance or corrects at hold_speed.
// cmd 2 disables hold. The eight configuration registers load through
// cfg_we/cfg_index/cfg_wdata and are meant to be written only while no beat
// is in flight.
module motor_position_move_and_hold
    import mpmh_pkg::*;
#(
    parameter int MAX_LEVEL_VALUE = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    mpmh_stream_if.sink         item,
    mpmh_stream_if.source       result,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata
);

    cfg_t    cfg;
    item_t   in_data_reg;
    logic    in_valid_reg, in_valid_next;
    result_t out_data_reg;
    logic    out_valid_reg, out_valid_next;
    result_t step_res;
    logic    out_free;
    logic    advance;
    logic    take;

    mpmh_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mpmh_ctrl #(
        .MAX_LEVEL_VALUE (MAX_LEVEL_VALUE)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (advance),
        .item  (in_data_reg),
        .res   (step_res)
    );

    // Result register is free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || result.ready;
    // Advance the held beat into the result register; state commits here.
    assign advance  = in_valid_reg && out_free;
    // Input slot is free when empty or moving on this cycle.
    assign item.ready = !in_valid_reg || out_free;
    assign take       = item.valid && item.ready;

    always_comb
    begin
        in_valid_next  = take || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on capture, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg <= item.data;
        end
        if (advance)
        begin
            out_data_reg <= step_res;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

// ===== sv/mpmh_checker.sv =====
// ----------------------------------------------------------------------------
// mpmh_checker: port-level checks for the move-and-hold controller
// Watch the result channel and check drive/status/hold consistency.
// ----------------------------------------------------------------------------
module mpmh_checker
    import mpmh_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    res_valid,
    input logic    res_ready,
    input result_t res_data
);

    // A stalled result beat holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result beat changed while stalled");

    // Rejected level: no drive at all.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.status == ST_INVALID) |->
            (res_data.drive == DRV_NONE) && (res_data.speed == '0))
        else $error("invalid level produced a drive");

    // Duty only goes with an increase or decrease drive.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.speed != '0) |->
            (res_data.drive == DRV_INC) || (res_data.drive == DRV_DEC))
        else $error("nonzero speed without a force drive");

    // Coast always releases hold; a move ending in brake enables it.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.drive == DRV_COAST) |-> !res_data.hold_active)
        else $error("coast with hold still active");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.drive == DRV_BRAKE) &&
        ((res_data.status == ST_REACHED) || (res_data.status == ST_TIMEOUT) ||
         (res_data.status == ST_STUCK)) |-> res_data.hold_active)
        else $error("move ended in brake without hold");

endmodule

bind motor_position_move_and_hold mpmh_checker u_mpmh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_data  (result.data)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for motor_position_move_and_hold
// Drives command beats through the valid/ready input channel, with random
// gaps on the sender side and random stalls on the result side. A scoreboard
// keeps its own copy of the controller state, predicts one result beat per
// accepted command beat and compares every field of the result stream. The
// run covers a directed pass, then well-formed move episodes, hold episodes
// and random noise under several register settings, zeros and ones included.
// ----------------------------------------------------------------------------
module testbench;
    import mpmh_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int LEVEL_LIMIT = 10;
    localparam int POS_MAX     = (1 <<< (PosW - 1)) - 1;
    localparam int POS_MIN     = -(1 <<< (PosW - 1));
    localparam int ITEM_GOAL   = 500;
    localparam int PHASES      = 6;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow controller state plus the queue of predicted beats
    // ------------------------------------------------------------------------
    class drive_scoreboard;
        cfg_t        cfg;
        bit          moving;
        bit          hold_on;
        bit          coast_at_end;
        int          aim;
        int          last_seen;
        int          run_ms;
        int          still_ms;
        int unsigned level_limit;
        result_t     expected_drive_q[$];
        int          failures;
        int          status_seen[8];

        function new(int unsigned limit);
            level_limit = limit;
            cfg         = CFG_RESET;
            moving      = 1'b0;
            hold_on     = 1'b0;
            coast_at_end = 1'b0;
            aim         = 0;
            last_seen   = 0;
            run_ms      = 0;
            still_ms    = 0;
            failures    = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int abs_ticks(int e);
            return (e < 0) ? -e : e;
        endfunction

        // Push toward the target; slow duty inside the slow-down band.
        function void steer(int err, inout result_t r);
            r.drive = (err > 0) ? DRV_INC : DRV_DEC;
            r.speed = (abs_ticks(err) <= cfg.slow_band) ? cfg.near_duty : cfg.far_duty;
        endfunction

        // A finished move either coasts and drops hold, or brakes and holds.
        function void finish_move(inout result_t r);
            moving = 1'b0;
            if (coast_at_end)
            begin
                hold_on = 1'b0;
                r.drive = DRV_COAST;
            end
            else
            begin
                hold_on = 1'b1;
                r.drive = DRV_BRAKE;
            end
        endfunction

        function void note_command(item_t it);
            int      pos;
            int      tgt;
            int      err;
            bit      restart;
            result_t r;
            pos      = int'($signed(it.position));
            tgt      = int'($signed(it.target_position));
            r.drive  = DRV_NONE;
            r.speed  = '0;
            r.status = ST_IDLE;
            restart  = (it.cmd == CMD_MOVE) && (it.level <= level_limit);

            // Millisecond counters advance only during a move, saturating.
            if (moving && it.ms_elapsed && !restart)
            begin
                if (run_ms < 65535) run_ms++;
                if (still_ms < 65535) still_ms++;
            end

            if (it.cmd == CMD_MOVE)
            begin
                if (!restart)
                begin
                    r.status = ST_INVALID;
                end
                else
                begin
                    err = tgt - pos;
                    aim = tgt;
                    if (abs_ticks(err) <= cfg.position_tolerance)
                    begin
                        moving   = 1'b0;
                        r.status = ST_NEAR;
                        if (it.level == 0)
                        begin
                            hold_on = 1'b0;
                            r.drive = DRV_COAST;
                        end
                        else
                        begin
                            hold_on = 1'b1;
                        end
                    end
                    else
                    begin
                        moving       = 1'b1;
                        coast_at_end = (it.level == 0);
                        run_ms       = 0;
                        still_ms     = 0;
                        last_seen    = pos;
                        r.status     = ST_MOVING;
                        steer(err, r);
                    end
                end
            end
            else if (it.cmd == CMD_RELEASE)
            begin
                hold_on  = 1'b0;
                r.status = moving ? ST_MOVING : ST_IDLE;
            end
            else if (it.cmd != CMD_SAMPLE)
            begin
                // unused command: report only
                r.status = moving ? ST_MOVING : (hold_on ? ST_HOLDING : ST_IDLE);
            end
            else if (moving)
            begin
                err = aim - pos;
                if (abs_ticks(err) <= cfg.position_tolerance)
                begin
                    finish_move(r);
                    r.status = ST_REACHED;
                end
                else if (run_ms > cfg.timeout_limit)
                begin
                    finish_move(r);
                    r.status = ST_TIMEOUT;
                end
                else
                begin
                    if (pos != last_seen)
                    begin
                        last_seen = pos;
                        still_ms  = 0;
                    end
                    if (still_ms > cfg.stuck_time_ms)
                    begin
                        finish_move(r);
                        r.status = ST_STUCK;
                    end
                    else
                    begin
                        r.status = ST_MOVING;
                        steer(err, r);
                    end
                end
            end
            else if (hold_on)
            begin
                err      = aim - pos;
                r.status = ST_HOLDING;
                if (abs_ticks(err) <= cfg.hold_tolerance)
                begin
                    r.drive = DRV_BRAKE;
                end
                else
                begin
                    r.drive = (err > 0) ? DRV_INC : DRV_DEC;
                    r.speed = cfg.hold_speed;
                end
            end

            r.hold_active = hold_on;
            expected_drive_q.push_back(r);
        endfunction

        function void flag(string field, logic [31:0] want, logic [31:0] got);
            failures++;
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
        endfunction

        function void check_drive(result_t got);
            result_t want;
            if (expected_drive_q.size() == 0)
            begin
                failures++;
                $error("result beat with no command pending: %p", got);
                return;
            end
            want = expected_drive_q.pop_front();
            if (got.drive !== want.drive) flag("drive", want.drive, got.drive);
            if (got.speed !== want.speed) flag("speed", want.speed, got.speed);
            if (got.status !== want.status) flag("status", want.status, got.status);
            if (got.hold_active !== want.hold_active)
                flag("hold_active", want.hold_active, got.hold_active);
            status_seen[int'(want.status)]++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_wdata;

    mpmh_stream_if #(.T(item_t))   item_ch ();
    mpmh_stream_if #(.T(result_t)) result_ch ();

    drive_scoreboard book = new(LEVEL_LIMIT);

    bit steady;         // suppress gaps and stalls on both sides
    int beats_sent;
    int settings_used;
    int shaft;          // simulated encoder position
    int aim;            // target of the current episode

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    motor_position_move_and_hold #(
        .MAX_LEVEL_VALUE(LEVEL_LIMIT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Sample both handshakes at the rising edge; note the command first so
    // the prediction is always queued ahead of any result check.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (item_ch.valid === 1'b1 && item_ch.ready === 1'b1)
                book.note_command(item_ch.data);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
                book.check_drive(result_ch.data);
        end
    end

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------

    // Idle length for either side: mostly none, sometimes short, rarely long.
    function automatic int idle_span();
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(12, 45);
    endfunction

    function automatic int clamp24(int v);
        if (v > POS_MAX) return POS_MAX;
        if (v < POS_MIN) return POS_MIN;
        return v;
    endfunction

    function automatic cfg_t draw_settings();
        cfg_t c;
        c.position_tolerance = $urandom_range(0, 64);
        c.hold_tolerance     = $urandom_range(0, 64);
        c.slow_band          = $urandom_range(0, 3000);
        c.far_duty           = $urandom;
        c.near_duty          = $urandom;
        c.hold_speed         = $urandom;
        c.timeout_limit      = $urandom_range(0, 60);
        c.stuck_time_ms      = $urandom_range(0, 12);
        return c;
    endfunction

    // Every task below starts and ends on a falling edge.
    task automatic send_command(cmd_t op, int pos, bit ms, int lvl, int tgt);
        item_t beat;
        int    pause;
        beat.cmd             = op;
        beat.position        = pos[PosW-1:0];
        beat.ms_elapsed      = ms;
        beat.level           = lvl[LevelW-1:0];
        beat.target_position = tgt[PosW-1:0];
        pause = idle_span();
        if (pause > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (pause) @(negedge clk);
        end
        item_ch.data  <= beat;
        item_ch.valid <= 1'b1;
        do @(posedge clk); while (item_ch.ready !== 1'b1);
        @(negedge clk);
        beats_sent++;
    endtask

    // Drop valid and hold until every predicted beat has come back, then
    // allow the two-stage pipe to settle.
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (book.expected_drive_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apply_settings(cfg_t c);
        cfg_idx_t       idx;
        logic [15:0]    value;
        wait_drained();
        idx = idx.first();
        repeat (idx.num())
        begin
            case (idx)
                CFG_POS_TOL:    value = c.position_tolerance;
                CFG_HOLD_TOL:   value = c.hold_tolerance;
                CFG_SLOW_BAND:  value = c.slow_band;
                CFG_NORMAL_SPD: value = {8'($urandom), c.far_duty};
                CFG_SLOW_SPD:   value = {8'($urandom), c.near_duty};
                CFG_HOLD_SPD:   value = {8'($urandom), c.hold_speed};
                CFG_TIMEOUT_MS: value = c.timeout_limit;
                default:        value = c.stuck_time_ms;
            endcase
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= value;
            @(negedge clk);
            idx = idx.next();
        end
        cfg_we <= 1'b0;
        book.cfg = c;
        settings_used++;
    endtask

    // One move: command, then a walk of samples toward the target, sometimes
    // with a frozen encoder, a hold release or a fresh target mid-way.
    task automatic move_episode();
        int span;
        int lvl;
        int step_ticks;
        bit frozen;
        case ($urandom_range(0, 3))
            0:       span = book.cfg.position_tolerance;
            1:       span = book.cfg.position_tolerance + book.cfg.slow_band + 2;
            2:       span = 100000;
            default: span = POS_MAX;
        endcase
        case ($urandom_range(0, 7))
            0:       lvl = $urandom_range(LEVEL_LIMIT + 1, 15);
            1, 2:    lvl = 0;
            default: lvl = $urandom_range(1, LEVEL_LIMIT);
        endcase
        aim = clamp24(shaft + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, span)));
        send_command(CMD_MOVE, shaft, $urandom_range(0, 1), lvl, aim);
        frozen = ($urandom_range(0, 5) == 0);
        repeat ($urandom_range(1, 20))
        begin
            if (!frozen)
            begin
                step_ticks = (aim - shaft) / int'($urandom_range(1, 4));
                shaft = shaft + step_ticks;
                if ($urandom_range(0, 7) == 0)
                    shaft = shaft + int'($urandom_range(0, 20)) - 10;
                shaft = clamp24(shaft);
            end
            case ($urandom_range(0, 19))
                0: send_command(CMD_RELEASE, shaft, $urandom_range(0, 1),
                                $urandom_range(0, 15), int'($urandom));
                1:
                begin
                    aim = clamp24(shaft + int'($urandom_range(0, 400)) - 200);
                    send_command(CMD_MOVE, shaft, $urandom_range(0, 1),
                                 $urandom_range(0, LEVEL_LIMIT), aim);
                end
                default: send_command(CMD_SAMPLE, shaft, $urandom_range(0, 1),
                                      $urandom_range(0, 15), int'($urandom));
            endcase
        end
    endtask

    // Wander around the last target so hold brakes and corrects both ways.
    task automatic hold_episode();
        int ht;
        ht = (book.cfg.hold_tolerance > 1000) ? 1000 : int'(book.cfg.hold_tolerance);
        repeat ($urandom_range(2, 10))
        begin
            shaft = clamp24(aim + int'($urandom_range(0, 2 * ht + 4)) - ht - 2);
            send_command(CMD_SAMPLE, shaft, $urandom_range(0, 1),
                         $urandom_range(0, 15), int'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: ready toggles in bursts, all high while steady
    // ------------------------------------------------------------------------
    initial
    begin : result_pacer
        int stall;
        result_ch.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = idle_span();
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        cfg_t quick;
        cfg_t phase_set;
        int   goal;
        int   roll;
        rst_n          = 1'b0;
        item_ch.valid  = 1'b0;
        item_ch.data   = '0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_POS_TOL;
        cfg_wdata      = '0;
        steady         = 1'b0;
        beats_sent     = 0;
        settings_used  = 0;
        shaft          = 0;
        aim            = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed pass on reset settings: rejected levels, already-near
        // with and without hold, hold brake and correction at the position
        // extremes, hold release, full-range move reaching with brake and
        // with coast, release during a move, a rejected level mid-move and
        // a replacing move.
        send_command(CMD_MOVE, 0, 0, 11, 1000);
        send_command(CMD_MOVE, 0, 0, 0, 3);
        send_command(CMD_MOVE, 0, 0, 7, -4);
        send_command(CMD_SAMPLE, -2, 1, 0, 0);
        send_command(CMD_SAMPLE, 100, 0, 0, 0);
        send_command(CMD_SAMPLE, POS_MIN, 0, 0, 0);
        send_command(CMD_RELEASE, 0, 0, 0, 0);
        send_command(CMD_MOVE, POS_MIN, 1, LEVEL_LIMIT, POS_MAX);
        send_command(CMD_SAMPLE, POS_MAX - 27, 1, 0, 0);
        send_command(CMD_SAMPLE, POS_MAX, 0, 0, 0);
        send_command(CMD_MOVE, 0, 0, 0, POS_MIN);
        send_command(CMD_RELEASE, 0, 1, 0, 0);
        send_command(CMD_SAMPLE, POS_MIN + 38, 1, 0, 0);
        send_command(CMD_SAMPLE, POS_MIN + 2, 0, 0, 0);
        send_command(CMD_MOVE, 0, 0, 3, 200);
        send_command(CMD_MOVE, 50, 1, 15, 0);
        send_command(CMD_MOVE, 50, 0, 4, -200);
        send_command(CMD_SAMPLE, -199, 1, 0, 0);

        // Short timers: a stalled encoder ends one move, the clock the next.
        quick = CFG_RESET;
        quick.timeout_limit = 16'd3;
        quick.stuck_time_ms = 16'd1;
        apply_settings(quick);
        send_command(CMD_MOVE, 0, 0, 2, 1000);
        send_command(CMD_SAMPLE, 0, 1, 0, 0);
        send_command(CMD_SAMPLE, 0, 1, 0, 0);
        send_command(CMD_MOVE, 0, 0, 0, -1000);
        for (int k = 1; k <= 4; k++)
            send_command(CMD_SAMPLE, -10 * k, 1, 0, 0);

        // Random phases: all zeros, all ones, then drawn settings; one phase
        // runs without any gaps or stalls.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       phase_set = '0;
                1:       phase_set = '1;
                default: phase_set = draw_settings();
            endcase
            apply_settings(phase_set);
            steady = (p == 3);
            shaft  = int'($urandom_range(0, 20000)) - 10000;
            goal   = beats_sent + ITEM_GOAL / PHASES;
            while (beats_sent < goal)
            begin
                // Hold off mid-phase until the result stream is empty.
                if (beats_sent >= goal - ITEM_GOAL / (2 * PHASES) &&
                    beats_sent < goal - ITEM_GOAL / (2 * PHASES) + 1)
                    wait_drained();
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    move_episode();
                else if (roll < 85)
                    hold_episode();
                else
                    send_command(cmd_t'($urandom_range(0, 2)), int'($urandom),
                                 $urandom_range(0, 1), $urandom_range(0, 15),
                                 int'($urandom));
            end
        end
        steady = 1'b0;

        wait_drained();
        $display("Sent %0d command beats under %0d register settings.",
                 beats_sent, settings_used + 1);
        $display("Outcomes: reached %0d, near %0d, timeout %0d, stuck %0d, invalid %0d, hold %0d",
                 book.status_seen[ST_REACHED], book.status_seen[ST_NEAR],
                 book.status_seen[ST_TIMEOUT], book.status_seen[ST_STUCK],
                 book.status_seen[ST_INVALID], book.status_seen[ST_HOLDING]);
        if (book.failures == 0 && book.expected_drive_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin : watchdog
        #(CLK_PERIOD * 400000);
        $error("watchdog expired with %0d result beats outstanding",
               book.expected_drive_q.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
